@@ hdl/button_press_classifier_top_assert.svh @@
// Assertion macros used by the button press classifier assertion monitor.
// Expects signals named clk and rst in the scope of use.
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/bpc_pkg.sv @@
// Package for the button press classifier: payload, config and state types, codes.
// No dependencies.
`timescale 1ns / 1ps

package bpc_pkg;

  // Press event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SHORT  = 2'd1;
  localparam logic [1:0] EV_LONG   = 2'd2;
  localparam logic [1:0] EV_DOUBLE = 2'd3;

  // Input action codes
  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Event enable mask bit positions
  localparam int unsigned MASK_SHORT  = 0;
  localparam int unsigned MASK_LONG   = 1;
  localparam int unsigned MASK_DOUBLE = 2;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_TICKS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_WINDOW = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_HOLD      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_MODE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_EVENT_MASK    = 3'd4;

  // Counter limits
  localparam logic [15:0] HOLD_MAX    = 16'hFFFF;
  localparam logic [16:0] RELEASE_MAX = 17'h1FFFF;

  typedef struct packed {
    logic action;
    logic key_down;
  } item_t;

  typedef struct packed {
    logic [1:0] press_event;
    logic       scanning;
  } result_t;

  typedef struct packed {
    logic [15:0] long_ticks;
    logic [15:0] double_window_ticks;
    logic [15:0] min_hold_ticks;
    logic        double_click_mode;
    logic [2:0]  event_enable_mask;
  } cfg_t;

  typedef struct packed {
    logic        scan_active;
    logic        hold_seen;
    logic [15:0] hold_count;
    logic        release_seen;
    logic [16:0] release_count;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    long_ticks:          16'd300,
    double_window_ticks: 16'd30,
    min_hold_ticks:      16'd0,
    double_click_mode:   1'b0,
    event_enable_mask:   3'd1
  };

  localparam state_t STATE_CLEAR = '{
    scan_active:   1'b0,
    hold_seen:     1'b0,
    hold_count:    16'd0,
    release_seen:  1'b0,
    release_count: 17'd0
  };

endpackage

@@ hdl/bpc_cfg.sv @@
// Configuration registers of the button press classifier.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bpc_pkg::cfg_t                   cfg
);

  bpc_pkg::cfg_t cfg_next;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    cfg_next = cfg;
    if (cfg_write_en) begin
      unique case (cfg_index)
        bpc_pkg::CFG_LONG_TICKS:    cfg_next.long_ticks          = cfg_data;
        bpc_pkg::CFG_DOUBLE_WINDOW: cfg_next.double_window_ticks = cfg_data;
        bpc_pkg::CFG_MIN_HOLD:      cfg_next.min_hold_ticks      = cfg_data;
        bpc_pkg::CFG_DOUBLE_MODE:   cfg_next.double_click_mode   = cfg_data[0];
        bpc_pkg::CFG_EVENT_MASK:    cfg_next.event_enable_mask   = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= bpc_pkg::CFG_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

@@ hdl/bpc_classify.sv @@
// Press classification: scan state registers and the per-item next-state logic.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_classify (
  input  logic             clk,
  input  logic             rst,
  input  bpc_pkg::cfg_t    cfg,
  input  logic             advance,
  input  bpc_pkg::item_t   item,
  output bpc_pkg::result_t result
);

  bpc_pkg::state_t st;
  bpc_pkg::state_t st_next;
  logic [1:0]      ev;
  logic [15:0]     hold_inc;
  logic [16:0]     release_inc;
  logic            dbl;

  assign dbl         = cfg.double_click_mode;
  assign hold_inc    = (st.hold_count < bpc_pkg::HOLD_MAX) ? st.hold_count + 16'd1
                                                           : st.hold_count;
  assign release_inc = (st.release_count < bpc_pkg::RELEASE_MAX)
                       ? st.release_count + 17'd1 : st.release_count;

  // Next state and event for the item in the input register
  always_comb begin
    st_next = st;
    ev      = bpc_pkg::EV_NONE;
    if (item.action == bpc_pkg::ACT_EDGE) begin
      st_next.scan_active = 1'b1;
    end else if (st.scan_active) begin
      if (item.key_down) begin
        if (dbl && st.release_seen) begin
          // Second press: scan stops, hold flag is set again straight after
          st_next           = bpc_pkg::STATE_CLEAR;
          st_next.hold_seen = 1'b1;
          if (cfg.event_enable_mask[bpc_pkg::MASK_DOUBLE]) ev = bpc_pkg::EV_DOUBLE;
        end else if (!st.hold_seen) begin
          st_next.hold_seen  = 1'b1;
          st_next.hold_count = 16'd0;
        end else begin
          st_next.hold_count = hold_inc;
          if (hold_inc >= cfg.long_ticks) begin
            st_next = bpc_pkg::STATE_CLEAR;
            if (cfg.event_enable_mask[bpc_pkg::MASK_LONG]) ev = bpc_pkg::EV_LONG;
          end
        end
      end else if (st.release_seen) begin
        if (dbl) begin
          st_next.release_count = release_inc;
          if (release_inc > {1'b0, cfg.double_window_ticks}) begin
            st_next = bpc_pkg::STATE_CLEAR;
            if (cfg.event_enable_mask[bpc_pkg::MASK_SHORT]) ev = bpc_pkg::EV_SHORT;
          end
        end else begin
          st_next = bpc_pkg::STATE_CLEAR;
          if (st.hold_count > cfg.min_hold_ticks &&
              cfg.event_enable_mask[bpc_pkg::MASK_SHORT]) begin
            ev = bpc_pkg::EV_SHORT;
          end
        end
      end else begin
        // First release of this press
        st_next.release_seen  = 1'b1;
        st_next.release_count = 17'd0;
        if (dbl) st_next.hold_count = 16'd0;
      end
    end
  end

  assign result.press_event = ev;
  assign result.scanning    = st_next.scan_active;

  // State moves only when the item moves on to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= bpc_pkg::STATE_CLEAR;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

@@ hdl/button_press_classifier_top.sv @@
// Top level of the button press classifier: input register, result register, config.
// Depends on bpc_pkg, bpc_cfg and bpc_classify.
`timescale 1ns / 1ps

// Classifies one push button as short, long or double press.
// Item channel (item_valid / item_stall / item_data): action 0 is an edge event
// that starts the scan, action 1 a scan tick carrying the qualified key level.
// Result channel (result_valid / result_stall / result_data): one result per
// item, press_event (0 none, 1 short, 2 long, 3 double) and the scan flag.
// Each result passes the input register, then the result register, before it
// is valid. Throughput: one item per cycle while the receiver does not stall,
// set by the single pass of compare and increment logic between the two
// registers.
// The input register takes an item while a finished result still waits, so a
// stalled receiver holds back the block only once both registers are full;
// item_stall then follows result_stall combinationally.
// Configuration: cfg_write_en, cfg_index and cfg_data write one register per
// cycle; write only while no item is in flight.
// Reset (rst, synchronous) empties both registers, clears the scan state and
// loads the register defaults (long 300, window 30, min hold 0, single-click
// mode, short press enabled only).
module button_press_classifier_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  bpc_pkg::item_t                  item_data,
  output logic                            result_valid,
  input  logic                            result_stall,
  output bpc_pkg::result_t                result_data,
  input  logic                            cfg_write_en,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bpc_pkg::cfg_t    cfg;
  bpc_pkg::item_t   s1_item;
  bpc_pkg::result_t s1_result;
  logic             s1_valid;
  logic             s1_advance;
  logic             item_take;

  bpc_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  bpc_classify u_classify (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (s1_advance),
    .item    (s1_item),
    .result  (s1_result)
  );

  // Handshake: input register moves on when the result register is free
  assign s1_advance = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_advance;
  assign item_take  = item_valid && !item_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) s1_item <= item_data;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) result_data <= s1_result;
  end

endmodule

@@ hdl/bpc_assert_mon.sv @@
// Port-level assertions for the button press classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier_top_assert.svh.
`timescale 1ns / 1ps
`include "button_press_classifier_top_assert.svh"

module bpc_assert_mon (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input bpc_pkg::result_t result_data
);

  // A stalled result is held unchanged
  `BPC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_data), "stalled result changed")

  // Any reported press ends the scan
  `BPC_ASSERT_NOW(a_event_stops, result_valid && result_data.press_event != bpc_pkg::EV_NONE, !result_data.scanning, "press reported while scan still active")

  // Items are held back only when a result waits on a stalled receiver
  `BPC_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall, "item stalled with result side free")

  // A stall on the item side lasts only while the result side is stalled
  `BPC_ASSERT_NEXT(a_stall_release, item_stall && !result_stall, !item_stall, "item stall outlived result stall")

  // A stalled item stays offered
  `BPC_ASSERT_NEXT(a_item_hold, item_valid && item_stall, item_valid, "stalled item withdrawn")

endmodule

bind button_press_classifier_top bpc_assert_mon u_bpc_assert_mon (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_data  (result_data)
);

@@ tb/button_press_classifier_checker.sv @@
// Checker for the button press classifier: watches the item, result and register ports,
// predicts each result and compares it with what the block returns.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module button_press_classifier_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_stall,
  input  bpc_pkg::item_t                  item_data,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  bpc_pkg::result_t                result_data,
  input  logic                            cfg_write_en,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                     pending,
  output int unsigned                     fail_count
);

  import bpc_pkg::*;

  cfg_t    regs = CFG_RESET;
  state_t  btn = STATE_CLEAR;
  result_t expected_results[$];

  // Work out the result of one item and advance the button state
  function automatic result_t classify_press(item_t it);
    result_t    res;
    logic [1:0] ev;
    logic       dbl;
    ev  = EV_NONE;
    dbl = regs.double_click_mode;
    if (it.action == ACT_EDGE) begin
      btn.scan_active = 1'b1;
    end else if (btn.scan_active) begin
      if (it.key_down) begin
        // second press inside the window; hold flag is set again just below
        if (dbl && btn.release_seen) begin
          btn = STATE_CLEAR;
          ev  = regs.event_enable_mask[MASK_DOUBLE] ? EV_DOUBLE : EV_NONE;
        end
        if (!btn.hold_seen) begin
          btn.hold_seen  = 1'b1;
          btn.hold_count = '0;
        end else begin
          if (btn.hold_count < HOLD_MAX) btn.hold_count++;
          if (btn.hold_count >= regs.long_ticks) begin
            btn = STATE_CLEAR;
            ev  = regs.event_enable_mask[MASK_LONG] ? EV_LONG : EV_NONE;
          end
        end
      end else if (btn.release_seen) begin
        if (dbl) begin
          if (btn.release_count < RELEASE_MAX) btn.release_count++;
          if (btn.release_count > {1'b0, regs.double_window_ticks}) begin
            btn = STATE_CLEAR;
            ev  = regs.event_enable_mask[MASK_SHORT] ? EV_SHORT : EV_NONE;
          end
        end else begin
          if (btn.hold_count > regs.min_hold_ticks)
            ev = regs.event_enable_mask[MASK_SHORT] ? EV_SHORT : EV_NONE;
          btn = STATE_CLEAR;
        end
      end else begin
        // first released tick
        btn.release_seen  = 1'b1;
        btn.release_count = '0;
        if (dbl) btn.hold_count = '0;
      end
    end
    res.press_event = ev;
    res.scanning    = btn.scan_active;
    return res;
  endfunction

  // Compare result transfers, then track register writes and item transfers
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      regs = CFG_RESET;
      btn  = STATE_CLEAR;
      expected_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: press_event %0d, scanning %0b",
                 result_data.press_event, result_data.scanning);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result_data.press_event !== want.press_event) begin
            $error("press_event: expected %0d, actual %0d",
                   want.press_event, result_data.press_event);
            fail_count++;
          end
          if (result_data.scanning !== want.scanning) begin
            $error("scanning: expected %0b, actual %0b", want.scanning, result_data.scanning);
            fail_count++;
          end
        end
      end
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_LONG_TICKS:    regs.long_ticks          = cfg_data;
          CFG_DOUBLE_WINDOW: regs.double_window_ticks = cfg_data;
          CFG_MIN_HOLD:      regs.min_hold_ticks      = cfg_data;
          CFG_DOUBLE_MODE:   regs.double_click_mode   = cfg_data[0];
          CFG_EVENT_MASK:    regs.event_enable_mask   = cfg_data[2:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall)
        expected_results.push_back(classify_press(item_data));
    end
    pending <= expected_results.size();
  end

endmodule

@@ tb/button_press_classifier_top_tb.sv @@
// Testbench top for the button press classifier: clock, reset, stimulus and verdict.
// Depends on bpc_pkg, button_press_classifier_top and button_press_classifier_checker.
`timescale 1ns / 1ps

module button_press_classifier_top_tb;

  import bpc_pkg::*;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  item_t                  item_data = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result_data;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int unsigned            pending;
  int unsigned            fail_count;

  int unsigned burst_left = 0;
  int unsigned cur_long = 300;
  int unsigned cur_window = 30;

  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_span = 0;
  int unsigned stall_tick = 0;

  button_press_classifier_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  button_press_classifier_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .fail_count   (fail_count)
  );

  always #5 clk = ~clk;

  // Receiver: switches between stall patterns, each held for a random span
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(20, 200);
    end
    stall_span--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:     result_stall <= 1'b0;
      STALL_RANDOM:   result_stall <= ($urandom_range(0, 99) < 30);
      STALL_PERIODIC: result_stall <= (stall_tick % 4 == 0);
      default:        result_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // One item transfer; valid stays high within a burst, drops for the gap after it
  task automatic send_item(input item_t it);
    item_valid <= 1'b1;
    item_data  <= it;
    do @(posedge clk); while (item_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic send_edge();
    item_t it;
    it.action   = ACT_EDGE;
    it.key_down = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  task automatic send_tick(input logic down);
    item_t it;
    it.action   = ACT_TICK;
    it.key_down = down;
    send_item(it);
  endtask

  // Hold off until every result is back and the pipeline has drained
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
  endtask

  // Writes every register; only called with the block idle
  task automatic set_config(input int unsigned long_t, input int unsigned window,
                            input int unsigned min_hold, input int unsigned mode,
                            input int unsigned mask);
    write_reg(CFG_LONG_TICKS, long_t[15:0]);
    write_reg(CFG_DOUBLE_WINDOW, window[15:0]);
    write_reg(CFG_MIN_HOLD, min_hold[15:0]);
    write_reg(CFG_DOUBLE_MODE, CFG_DATA_W'(mode[0]));
    write_reg(CFG_EVENT_MASK, CFG_DATA_W'(mask[2:0]));
    cfg_write_en <= 1'b0;
    cur_long   = 32'(long_t[15:0]);
    cur_window = 32'(window[15:0]);
  endtask

  // Mostly well-formed presses sized around the thresholds, capped at 24 ticks, some noise
  task automatic press_sequences(input int unsigned target);
    int unsigned sent, hold_len, rel_len, hold_cap, rel_cap;
    item_t       noise;
    sent     = 0;
    hold_cap = (cur_long + 2 > 24) ? 24 : cur_long + 2;
    rel_cap  = (cur_window + 3 > 24) ? 24 : cur_window + 3;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 8) begin
        send_edge();
        if ($urandom_range(0, 4) == 0) send_edge();
        hold_len = $urandom_range(1, hold_cap);
        rel_len  = $urandom_range(1, rel_cap);
        repeat (hold_len) send_tick(1'b1);
        repeat (rel_len) send_tick(1'b0);
        sent += 1 + hold_len + rel_len;
        // a second press, a double press where the window is still open
        if ($urandom_range(0, 2) == 0) begin
          hold_len = $urandom_range(1, 3);
          rel_len  = $urandom_range(1, rel_cap);
          repeat (hold_len) send_tick(1'b1);
          repeat (rel_len) send_tick(1'b0);
          sent += hold_len + rel_len;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          noise.action   = 1'($urandom_range(0, 1));
          noise.key_down = 1'($urandom_range(0, 1));
          send_item(noise);
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: ticks while idle, repeated edge, single-click short press
    send_tick(1'b0);
    send_tick(1'b1);
    send_edge();
    send_edge();
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    wait_idle();

    // Double-click mode: double press, then the hold flag carries into a long press,
    // then a short press once the window runs out
    set_config(2, 2, 0, 1, 7);
    send_edge();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_edge();
    send_tick(1'b1);
    send_tick(1'b1);
    send_edge();
    send_tick(1'b1);
    send_tick(1'b0);
    repeat (4) send_tick(1'b0);
    wait_idle();

    // Zero long threshold with every event masked off
    set_config(0, 0, 0, 0, 0);
    send_edge();
    send_tick(1'b1);
    send_tick(1'b1);
    wait_idle();

    // Random phases across a range of settings, extremes first
    set_config(1, 0, 0, 1, 7);
    press_sequences(65);
    wait_idle();
    set_config(3, 4, 1, 0, 7);
    press_sequences(65);
    wait_idle();
    set_config(0, 2, 0, 1, 5);
    press_sequences(65);
    wait_idle();
    set_config(65535, 65535, 65535, 0, 7);
    press_sequences(65);
    wait_idle();
    set_config(65535, 65535, 0, 1, 7);
    press_sequences(65);
    wait_idle();
    repeat (5) begin
      set_config($urandom_range(1, 10), $urandom_range(0, 6), $urandom_range(0, 4),
                 $urandom_range(0, 1), $urandom_range(0, 7));
      press_sequences(65);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("button_press_classifier_top_tb OK");
    end else begin
      $display("button_press_classifier_top_tb NOT OK");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run
  initial begin
    #20_000_000;
    $display("button_press_classifier_top_tb NOT OK");
    $finish;
  end

endmodule
